[rtl/ldma_pkg.sv]
// Package for the moving-average landing detector.
// Widths, register indexes, item kinds and datapath command/status types.
package ldma_pkg;

  localparam int WindowDefault = 10;
  localparam int SampleW = 16;
  localparam int CfgW = 12;
  localparam int CountW = 10;
  localparam int CfgIdxW = 3;
  localparam int KindW = 3;
  localparam logic [CountW-1:0] CountMax = '1;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegNearMargin  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTightMargin = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAccelLimit  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegVelLimit    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDwellTicks  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGroundWait  = 3'd5;

  // item kinds
  localparam logic [KindW-1:0] KindAlt   = 3'd0;
  localparam logic [KindW-1:0] KindAccel = 3'd1;
  localparam logic [KindW-1:0] KindVel   = 3'd2;
  localparam logic [KindW-1:0] KindTick  = 3'd3;
  localparam logic [KindW-1:0] KindStart = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic       push;      // start a window push (sum update, latch sample)
    logic [1:0] sel;       // window selected
    logic       div_start; // start mean division
    logic       start;     // arm detection
    logic       tick;      // evaluate rules on a tick
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
  } dp_sts_t;

endpackage

[rtl/ldma_if.sv]
// Valid/ready stream interface used by both channels.
// Depends on nothing; payload type given as a parameter.
interface ldma_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/ldma_ctrl.sv]
// Controller FSM of the landing detector: sequences push, divide and tick.
// Depends on ldma_pkg.
module ldma_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [ldma_pkg::KindW-1:0] in_kind,
  output logic                       in_ready,
  input  logic                       out_busy,
  output logic                       out_load,
  output ldma_pkg::dp_cmd_t          cmd,
  input  ldma_pkg::dp_sts_t          sts
);

  typedef enum logic [1:0] {S_IDLE, S_SUM, S_DIV, S_WAIT} state_t;
  state_t state_r, state_nxt;

  logic fire;
  assign in_ready = (state_r == S_IDLE) && !out_busy;
  assign fire = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    out_load = 1'b0;
    cmd.sel = in_kind[1:0];
    case (state_r)
      S_IDLE: begin
        if (fire) begin
          case (in_kind)
            ldma_pkg::KindAlt, ldma_pkg::KindAccel, ldma_pkg::KindVel: begin
              cmd.push = 1'b1;
              state_nxt = S_SUM;
            end
            ldma_pkg::KindStart: cmd.start = 1'b1;
            ldma_pkg::KindTick: begin
              cmd.tick = 1'b1;
              out_load = 1'b1;
            end
            default: ;
          endcase
        end
      end
      // window sum and fill are updated in this cycle
      S_SUM: state_nxt = S_DIV;
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: if (!sts.div_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

[rtl/ldma_dp.sv]
// Datapath: three sliding windows, serial mean divider, ground and dwell rules.
// Depends on ldma_pkg.
module ldma_dp #(
  parameter int WINDOW = ldma_pkg::WindowDefault
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ldma_pkg::dp_cmd_t                  cmd,
  output ldma_pkg::dp_sts_t                  sts,
  input  logic signed [ldma_pkg::SampleW-1:0] sample,
  input  logic [ldma_pkg::CfgW-1:0]          near_margin,
  input  logic [ldma_pkg::CfgW-1:0]          tight_margin,
  input  logic [ldma_pkg::CfgW-1:0]          accel_limit,
  input  logic [ldma_pkg::CfgW-1:0]          vel_limit,
  input  logic [ldma_pkg::CountW-1:0]        dwell_ticks,
  input  logic [ldma_pkg::CountW-1:0]        ground_wait,
  output logic                               r_landed,
  output logic                               r_height_ok,
  output logic                               r_accel_ok,
  output logic                               r_vel_ok,
  output logic                               r_ground_valid,
  output logic signed [ldma_pkg::SampleW-1:0] r_alt_mean
);

  localparam int IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FillW = $clog2(WINDOW + 1);
  localparam int SumW = ldma_pkg::SampleW + FillW;
  localparam int MagW = SumW;
  localparam int StepW = $clog2(MagW + 1);
  localparam int BndW = SumW + 2;
  localparam int ProdW = BndW + FillW + 1;
  localparam logic [FillW-1:0] FillFull = FillW'(WINDOW);
  localparam logic [IdxW-1:0] HeadLast = IdxW'(WINDOW - 1);

  // window memories
  logic signed [ldma_pkg::SampleW-1:0] win0 [WINDOW];
  logic signed [ldma_pkg::SampleW-1:0] win1 [WINDOW];
  logic signed [ldma_pkg::SampleW-1:0] win2 [WINDOW];
  logic signed [SumW-1:0] sum_r [3];
  logic [FillW-1:0] fill_r [3];
  logic [IdxW-1:0] head_r [3];
  logic signed [ldma_pkg::SampleW-1:0] mean0_r;

  logic signed [ldma_pkg::SampleW-1:0] old_r, smp_r;
  logic [1:0] sel_r;
  logic phase_r;

  logic signed [ldma_pkg::SampleW-1:0] ground_r;
  logic ground_set_r;
  logic [ldma_pkg::CountW-1:0] ticks_r;
  logic [ldma_pkg::CountW-1:0] dwell_r [3];
  logic [1:0] still_r;
  logic active_r, landed_r;

  // divider
  logic [MagW-1:0] quo_r, rem_r;
  logic [StepW-1:0] cnt_r;
  logic neg_r, busy_r;
  logic [MagW:0] rem_sh;
  logic phase_done_r;

  assign sts.div_busy = busy_r;

  // push: read oldest entry in first cycle, update sum in the next
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      sel_r <= cmd.sel;
      smp_r <= sample;
      case (cmd.sel)
        2'd0: old_r <= win0[head_r[0]];
        2'd1: old_r <= win1[head_r[1]];
        default: old_r <= win2[head_r[2]];
      endcase
    end
    if (phase_r) begin
      case (sel_r)
        2'd0: win0[head_r[0]] <= smp_r;
        2'd1: win1[head_r[1]] <= smp_r;
        default: win2[head_r[2]] <= smp_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
        fill_r[i] <= '0;
        head_r[i] <= '0;
      end
    end else begin
      phase_r <= cmd.push;
      if (phase_r) begin
        sum_r[sel_r] <= sum_r[sel_r] + SumW'(smp_r)
                        - ((fill_r[sel_r] == FillFull) ? SumW'(old_r) : SumW'(0));
        head_r[sel_r] <= (head_r[sel_r] == HeadLast) ? '0 : head_r[sel_r] + 1'b1;
        if (fill_r[sel_r] != FillFull) fill_r[sel_r] <= fill_r[sel_r] + 1'b1;
      end
    end
  end

  // one-shot marker that a division has just finished
  always_ff @(posedge clk) begin
    if (!rst_n) phase_done_r <= 1'b0;
    else phase_done_r <= busy_r && (cnt_r == StepW'(1));
  end

  // restoring divider, one quotient bit per cycle; only altitude mean is kept
  assign rem_sh = {rem_r, quo_r[MagW-1]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mean0_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      busy_r <= 1'b1;
      neg_r <= sum_r[sel_r][SumW-1];
      quo_r <= sum_r[sel_r][SumW-1] ? MagW'(-sum_r[sel_r]) : MagW'(sum_r[sel_r]);
      rem_r <= '0;
      cnt_r <= StepW'(MagW);
    end else if (busy_r) begin
      if (rem_sh >= (MagW+1)'(fill_r[sel_r])) begin
        rem_r <= MagW'(rem_sh - (MagW+1)'(fill_r[sel_r]));
        quo_r <= {quo_r[MagW-2:0], 1'b1};
      end else begin
        rem_r <= MagW'(rem_sh);
        quo_r <= {quo_r[MagW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == StepW'(1)) begin
        busy_r <= 1'b0;
      end
    end else if (phase_done_r && sel_r == 2'd0) begin
      mean0_r <= neg_r ? ldma_pkg::SampleW'(-quo_r) : ldma_pkg::SampleW'(quo_r);
    end
  end

  // rule evaluation
  logic signed [BndW-1:0] nb, tb;
  logic signed [ProdW-1:0] nbf, tbf, abf, vbf;
  logic near, vnear, asml, vsml;
  logic [ldma_pkg::CountW-1:0] hinc, ainc, vinc;
  logic h_ok, a_ok, v_ok;

  always_comb begin
    nb = BndW'(ground_r) + BndW'(near_margin);
    tb = BndW'(ground_r) + BndW'(tight_margin);
    nbf = ProdW'(nb) * ProdW'($signed({1'b0, fill_r[0]}));
    tbf = ProdW'(tb) * ProdW'($signed({1'b0, fill_r[0]}));
    abf = ProdW'($signed({1'b0, accel_limit})) * ProdW'($signed({1'b0, fill_r[1]}));
    vbf = ProdW'($signed({1'b0, vel_limit})) * ProdW'($signed({1'b0, fill_r[2]}));
    near = (fill_r[0] == '0) ? (nb >= 0) : (ProdW'(sum_r[0]) <= nbf);
    vnear = (fill_r[0] == '0) ? (tb >= 0) : (ProdW'(sum_r[0]) <= tbf);
    asml = (ProdW'(sum_r[1]) <= abf) && (ProdW'(sum_r[1]) >= -abf);
    vsml = (ProdW'(sum_r[2]) <= vbf) && (ProdW'(sum_r[2]) >= -vbf);
    hinc = (dwell_r[0] == ldma_pkg::CountMax) ? dwell_r[0] : dwell_r[0] + 1'b1;
    ainc = (dwell_r[1] == ldma_pkg::CountMax) ? dwell_r[1] : dwell_r[1] + 1'b1;
    vinc = (dwell_r[2] == ldma_pkg::CountMax) ? dwell_r[2] : dwell_r[2] + 1'b1;
    h_ok = active_r && near && (hinc > dwell_ticks);
    a_ok = active_r && near && asml && still_r[0] && (ainc > dwell_ticks);
    v_ok = active_r && vnear && vsml && still_r[1] && (vinc > dwell_ticks);
  end

  // detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ground_r <= '0;
      ground_set_r <= 1'b0;
      ticks_r <= '0;
      still_r <= '0;
      active_r <= 1'b0;
      landed_r <= 1'b0;
      for (int i = 0; i < 3; i++) dwell_r[i] <= '0;
    end else begin
      if (cmd.push && cmd.sel == 2'd0 && !ground_set_r && ticks_r >= ground_wait) begin
        ground_r <= sample;
        ground_set_r <= 1'b1;
      end
      if (cmd.start) begin
        active_r <= 1'b1;
        still_r <= '0;
        for (int i = 0; i < 3; i++) dwell_r[i] <= '0;
      end
      if (cmd.tick) begin
        if (ticks_r != ldma_pkg::CountMax) ticks_r <= ticks_r + 1'b1;
        if (active_r) begin
          dwell_r[0] <= near ? hinc : '0;
          if (near && asml) begin
            still_r[0] <= 1'b1;
            dwell_r[1] <= still_r[0] ? ainc : '0;
          end else begin
            still_r[0] <= 1'b0;
            dwell_r[1] <= '0;
          end
          if (vnear && vsml) begin
            still_r[1] <= 1'b1;
            dwell_r[2] <= still_r[1] ? vinc : '0;
          end else begin
            still_r[1] <= 1'b0;
            dwell_r[2] <= '0;
          end
          if (h_ok || a_ok || v_ok) landed_r <= 1'b1;
        end
      end
    end
  end

  assign r_landed = landed_r || h_ok || a_ok || v_ok;
  assign r_height_ok = h_ok;
  assign r_accel_ok = a_ok;
  assign r_vel_ok = v_ok;
  assign r_ground_valid = ground_set_r;
  assign r_alt_mean = mean0_r;

endmodule

[rtl/landing_detector_moving_average.sv]
// Top level of the moving-average landing detector.
// Depends on ldma_pkg, ldma_if, ldma_ctrl and ldma_dp.
// A sample item (altitude, acceleration, velocity) is accepted in idle; the window
// sum is then updated, the bit-serial divider forming the mean is started and run
// over all SUM bits, and the controller returns to idle. Ticks and start items are
// handled as they are accepted. No item is taken while the controller is not idle
// or a result waits. One result per tick sits in an output register.
module landing_detector_moving_average #(
  parameter int WINDOW = ldma_pkg::WindowDefault
) (
  input  logic clk,
  input  logic rst_n,
  ldma_if.sink   in_ch,
  ldma_if.source out_ch,
  input  logic                              cfg_we,
  input  logic [ldma_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [ldma_pkg::CfgW-1:0]         cfg_data
);

  logic [ldma_pkg::CfgW-1:0] near_r, tight_r, acc_r, vel_r;
  logic [ldma_pkg::CountW-1:0] dwell_r, wait_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= 12'd200; tight_r <= 12'd100; acc_r <= 12'd100; vel_r <= 12'd100;
      dwell_r <= 10'd60; wait_r <= 10'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        ldma_pkg::RegNearMargin:  near_r <= cfg_data;
        ldma_pkg::RegTightMargin: tight_r <= cfg_data;
        ldma_pkg::RegAccelLimit:  acc_r <= cfg_data;
        ldma_pkg::RegVelLimit:    vel_r <= cfg_data;
        ldma_pkg::RegDwellTicks:  dwell_r <= cfg_data[ldma_pkg::CountW-1:0];
        ldma_pkg::RegGroundWait:  wait_r <= cfg_data[ldma_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  ldma_pkg::dp_cmd_t cmd;
  ldma_pkg::dp_sts_t sts;
  logic out_load, ovalid_r;
  logic l, h, a, v, g;
  logic signed [ldma_pkg::SampleW-1:0] m;

  ldma_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_kind(in_ch.payload.kind), .in_ready(in_ch.ready),
    .out_busy(ovalid_r && !out_ch.ready), .out_load, .cmd, .sts
  );

  ldma_dp #(.WINDOW(WINDOW)) u_dp (
    .clk, .rst_n, .cmd, .sts, .sample(in_ch.payload.sample),
    .near_margin(near_r), .tight_margin(tight_r), .accel_limit(acc_r),
    .vel_limit(vel_r), .dwell_ticks(dwell_r), .ground_wait(wait_r),
    .r_landed(l), .r_height_ok(h), .r_accel_ok(a), .r_vel_ok(v),
    .r_ground_valid(g), .r_alt_mean(m)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (out_load) ovalid_r <= 1'b1;
    else if (out_ch.ready) ovalid_r <= 1'b0;
    if (out_load) begin
      out_ch.payload.landed <= l;
      out_ch.payload.height_ok <= h;
      out_ch.payload.accel_ok <= a;
      out_ch.payload.vel_ok <= v;
      out_ch.payload.ground_valid <= g;
      out_ch.payload.altitude_mean <= m;
    end
  end
  assign out_ch.valid = ovalid_r;

endmodule
